// ----- sv/tp_pkg.sv -----
package tp_pkg;

	localparam int COORD_BITS = 16;
	// |difference| of two coordinates still fits COORD_BITS unsigned bits
	localparam int DIFF_BITS  = COORD_BITS;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int ROOT_BITS  = COORD_BITS + 1;
	localparam int RAD_BITS   = 2 * ROOT_BITS;
	localparam int REM_BITS   = ROOT_BITS + 2;
	// output fields are wide enough for any root and for the sum of three roots, nothing wraps
	localparam int SIDE_BITS  = 17;
	localparam int PERIM_BITS = 19;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIFF_BITS-1:0]         diff_t;
	typedef logic [SQ_BITS-1:0]           sq_t;
	typedef logic [SUM_BITS-1:0]          sum_t;
	typedef logic [ROOT_BITS-1:0]         root_t;
	typedef logic [SIDE_BITS-1:0]         side_t;
	typedef logic [PERIM_BITS-1:0]        perim_t;

	// working set of the digit-by-digit square root
	typedef struct packed {
		logic [REM_BITS-1:0] rem;
		root_t               root;
		logic [RAD_BITS-1:0] rad;
	} sqrt_t;

endpackage

// ----- sv/tp_root_step.sv -----
module tp_root_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tp_pkg::sqrt_t in_data,
	output logic          out_valid,
	output tp_pkg::sqrt_t out_data
);
	import tp_pkg::*;

	logic [REM_BITS+1:0] cand;
	logic [REM_BITS+1:0] trial;
	logic [REM_BITS+1:0] diff;
	logic                take;
	sqrt_t               next;
	sqrt_t               data_s1;
	logic                valid_s1;

	always_comb begin
		// bring down the next two radicand bits, try root digit one
		cand  = {in_data.rem, in_data.rad[RAD_BITS-1 -: 2]};
		trial = {{(REM_BITS-ROOT_BITS){1'b0}}, in_data.root, 2'b01};
		diff  = cand - trial;
		take  = (cand >= trial);
		next.rem  = take ? diff[REM_BITS-1:0] : cand[REM_BITS-1:0];
		next.root = {in_data.root[ROOT_BITS-2:0], take};
		next.rad  = {in_data.rad[RAD_BITS-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= next;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- sv/tp_side.sv -----
module tp_side (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  tp_pkg::coord_t px,
	input  tp_pkg::coord_t py,
	input  tp_pkg::coord_t qx,
	input  tp_pkg::coord_t qy,
	output logic           out_valid,
	output tp_pkg::root_t  length
);
	import tp_pkg::*;

	logic [COORD_BITS:0] dx_raw;
	logic [COORD_BITS:0] dy_raw;
	logic [COORD_BITS:0] dx_abs;
	logic [COORD_BITS:0] dy_abs;

	diff_t dx_s1, dy_s1;
	sq_t   sqx_s2, sqy_s2;
	sum_t  sum_s3;
	logic  valid_s1, valid_s2, valid_s3;

	sqrt_t              chain [ROOT_BITS+1];
	logic [ROOT_BITS:0] chain_vld;

	always_comb begin
		dx_raw = {px[COORD_BITS-1], px} - {qx[COORD_BITS-1], qx};
		dy_raw = {py[COORD_BITS-1], py} - {qy[COORD_BITS-1], qy};
		dx_abs = dx_raw[COORD_BITS] ? -dx_raw : dx_raw;
		dy_abs = dy_raw[COORD_BITS] ? -dy_raw : dy_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx_abs[DIFF_BITS-1:0];
		dy_s1  <= dy_abs[DIFF_BITS-1:0];
		sqx_s2 <= SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
		sqy_s2 <= SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
		sum_s3 <= SUM_BITS'(sqx_s2) + SUM_BITS'(sqy_s2);
	end

	assign chain[0].rem  = '0;
	assign chain[0].root = '0;
	assign chain[0].rad  = {{(RAD_BITS-SUM_BITS){1'b0}}, sum_s3};
	assign chain_vld[0]  = valid_s3;

	// one root bit per stage, most significant first
	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
		tp_root_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[k]),
			.in_data   (chain[k]),
			.out_valid (chain_vld[k+1]),
			.out_data  (chain[k+1])
		);
	end

	assign out_valid = chain_vld[ROOT_BITS];
	assign length    = chain[ROOT_BITS].root;

endmodule

// ----- sv/triangle_perimeter.sv -----
// pipeline: a request taken with start shows its result with done high
// after 3 difference/square/sum stages, 17 root stages and 1 sum stage
// throughput: one triangle per cycle; busy is always low and start may be
// held high every cycle, the receiver cannot stall the pipeline
// reset: arst_n clears all valid bits at once, so no stale done comes out
module triangle_perimeter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tp_pkg::coord_t   vertex_a_x,
	input  tp_pkg::coord_t   vertex_a_y,
	input  tp_pkg::coord_t   vertex_b_x,
	input  tp_pkg::coord_t   vertex_b_y,
	input  tp_pkg::coord_t   vertex_c_x,
	input  tp_pkg::coord_t   vertex_c_y,
	output logic             done,
	output tp_pkg::side_t    side_bc,
	output tp_pkg::side_t    side_ac,
	output tp_pkg::side_t    side_ab,
	output tp_pkg::perim_t   perimeter
);
	import tp_pkg::*;

	logic  accept;
	logic  vld_bc, vld_ac, vld_ab;
	root_t len_bc, len_ac, len_ab;

	logic   done_q;
	side_t  side_bc_q, side_ac_q, side_ab_q;
	perim_t perimeter_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	tp_side u_bc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.px        (vertex_b_x),
		.py        (vertex_b_y),
		.qx        (vertex_c_x),
		.qy        (vertex_c_y),
		.out_valid (vld_bc),
		.length    (len_bc)
	);

	tp_side u_ac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.px        (vertex_a_x),
		.py        (vertex_a_y),
		.qx        (vertex_c_x),
		.qy        (vertex_c_y),
		.out_valid (vld_ac),
		.length    (len_ac)
	);

	tp_side u_ab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.px        (vertex_a_x),
		.py        (vertex_a_y),
		.qx        (vertex_b_x),
		.qy        (vertex_b_y),
		.out_valid (vld_ab),
		.length    (len_ab)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			// the three lanes run in lockstep
			done_q <= vld_bc & vld_ac & vld_ab;
		end
	end

	always_ff @(posedge clk) begin
		side_bc_q   <= SIDE_BITS'(len_bc);
		side_ac_q   <= SIDE_BITS'(len_ac);
		side_ab_q   <= SIDE_BITS'(len_ab);
		perimeter_q <= PERIM_BITS'(len_bc) + PERIM_BITS'(len_ac) + PERIM_BITS'(len_ab);
	end

	assign done      = done_q;
	assign side_bc   = side_bc_q;
	assign side_ac   = side_ac_q;
	assign side_ab   = side_ab_q;
	assign perimeter = perimeter_q;

endmodule
